### sv/lps_pkg.sv
package lps_pkg;

  typedef enum logic [1:0] {
    MODE_BOUNCE = 2'd0,
    MODE_COUNT  = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_STACK  = 2'd3
  } mode_t;

  localparam logic [7:0] LED_LEFT   = 8'h80;
  localparam logic [7:0] LED_RIGHT  = 8'h01;
  localparam logic [7:0] LED_PAIR   = 8'h81;
  localparam logic [4:0] HALF_SWEEP = 5'd7;
  localparam logic [4:0] FULL_SWEEP = 5'd14;
  localparam logic [4:0] HALF_STACK = 5'd8;
  localparam logic [4:0] FULL_STACK = 5'd16;

  typedef struct packed {
    logic [1:0] requested_mode;
    mode_t      active_mode;
    logic [4:0] step_index;
    logic [7:0] pattern;
    logic [3:0] count_value;
    logic       count_down;
    logic [5:0] wait_left;
    logic [7:0] left_bit;
    logic [7:0] right_bit;
  } lps_state_t;

  typedef struct packed {
    logic       tick;
    logic       mode_press;
    logic [1:0] mode_bits;
    logic       dir_press;
    logic [1:0] speed_select;
    logic [3:0] start_count;
  } lps_item_t;

  // Ticks per step for each speed select code.
  function automatic logic [5:0] wait_ticks(input logic [1:0] speed);
    logic [5:0] w;
    case (speed)
      2'd0:    w = 6'd2;
      2'd1:    w = 6'd10;
      2'd2:    w = 6'd20;
      default: w = 6'd40;
    endcase
    return w;
  endfunction

endpackage

### sv/lps_step.sv
module lps_step
  import lps_pkg::*;
(
  input  lps_state_t cur,
  input  lps_item_t  item,
  output lps_state_t nxt,
  output logic       stepped
);

  lps_state_t s;
  logic [5:0] wait_dec;

  always_comb begin
    s        = cur;
    stepped  = 1'b0;
    wait_dec = 6'd0;

    if (item.mode_press) begin
      s.requested_mode = item.mode_bits;
    end
    if (item.dir_press) begin
      s.count_down = ~s.count_down;
    end

    if (item.tick) begin
      wait_dec    = (s.wait_left != 6'd0) ? s.wait_left - 6'd1 : 6'd0;
      s.wait_left = wait_dec;
      if (wait_dec == 6'd0) begin
        // mode change is only taken up at the end of a wait
        if (s.requested_mode != s.active_mode) begin
          s.active_mode = mode_t'(s.requested_mode);
          case (s.active_mode)
            MODE_BOUNCE: begin
              s.pattern    = LED_LEFT;
              s.step_index = 5'd0;
            end
            MODE_COUNT: begin
              s.count_value = item.start_count;
            end
            MODE_DOUBLE: begin
              s.pattern    = LED_PAIR;
              s.left_bit   = LED_LEFT;
              s.right_bit  = LED_RIGHT;
              s.step_index = 5'd0;
            end
            default: begin
              s.pattern    = 8'h00;
              s.left_bit   = LED_LEFT;
              s.right_bit  = LED_RIGHT;
              s.step_index = 5'd0;
            end
          endcase
        end

        case (s.active_mode)
          MODE_BOUNCE: begin
            if (s.step_index < HALF_SWEEP) begin
              s.pattern    = s.pattern >> 1;
              s.step_index = s.step_index + 5'd1;
            end else if (s.step_index < FULL_SWEEP) begin
              s.pattern    = s.pattern << 1;
              s.step_index = s.step_index + 5'd1;
            end else begin
              s.step_index = 5'd0;
            end
          end
          MODE_COUNT: begin
            s.pattern     = {4'd0, s.count_value};
            s.count_value = s.count_down ? s.count_value - 4'd1 : s.count_value + 4'd1;
          end
          MODE_DOUBLE: begin
            if (s.step_index < HALF_SWEEP) begin
              s.pattern    = s.left_bit | s.right_bit;
              s.left_bit   = s.left_bit >> 1;
              s.right_bit  = s.right_bit << 1;
              s.step_index = s.step_index + 5'd1;
            end else if (s.step_index < FULL_SWEEP) begin
              s.pattern    = s.left_bit | s.right_bit;
              s.left_bit   = s.left_bit << 1;
              s.right_bit  = s.right_bit >> 1;
              s.step_index = s.step_index + 5'd1;
            end else begin
              s.step_index = 5'd0;
              s.left_bit   = LED_LEFT;
              s.right_bit  = LED_RIGHT;
            end
          end
          default: begin
            if (s.step_index < HALF_STACK) begin
              s.pattern    = s.pattern ^ s.left_bit;
              s.left_bit   = s.left_bit >> 1;
              s.step_index = s.step_index + 5'd1;
            end else if (s.step_index < FULL_STACK) begin
              s.pattern    = s.pattern ^ s.right_bit;
              s.right_bit  = s.right_bit << 1;
              s.step_index = s.step_index + 5'd1;
            end else begin
              s.step_index = 5'd0;
              s.left_bit   = LED_LEFT;
              s.right_bit  = LED_RIGHT;
            end
          end
        endcase

        s.wait_left = wait_ticks(item.speed_select);
        stepped     = 1'b1;
      end
    end

    nxt = s;
  end

endmodule

### sv/led_pattern_sequencer.sv
// LED pattern sequencer.
// Input channel in_*: one item per time-base tick or button event. Each item
// carries tick, mode_press, mode_bits, dir_press, speed_select, start_count.
// Result channel out_*: exactly one item per accepted input item, giving the
// LED byte after that item and a flag set when the sequencer took a step.
// Latency: the result is valid the cycle after the input item is accepted.
// Throughput: one item per cycle while the receiver is not stalling; the state update is a single combinational
// pass between the state register and the output register.
// The output register parts the two sides: a new item is accepted whenever
// the output register is empty or is being emptied in the same cycle. If the
// receiver stalls, the result is held and in_tready drops until it is taken.
// Reset (rst_n low, synchronous): mode 0 (bounce), LEDs 0x80, counting up,
// wait count 1 so that the first tick steps, output channel empty.
module led_pattern_sequencer
  import lps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] tick, [1] mode_press, [3:2] mode_bits, [4] dir_press,
  // [6:5] speed_select, [10:7] start_count, [15:11] zero
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] led_pattern, [8] stepped, [15:9] zero
  output logic [15:0] out_tdata
);

  lps_state_t state_r;
  lps_state_t state_nxt;
  lps_item_t  item;
  logic       stepped;
  logic       out_valid_r;
  logic [8:0] out_data_r;
  logic       in_fire;

  assign item.tick         = in_tdata[0];
  assign item.mode_press   = in_tdata[1];
  assign item.mode_bits    = in_tdata[3:2];
  assign item.dir_press    = in_tdata[4];
  assign item.speed_select = in_tdata[6:5];
  assign item.start_count  = in_tdata[10:7];

  lps_step u_step (
    .cur     (state_r),
    .item    (item),
    .nxt     (state_nxt),
    .stepped (stepped)
  );

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.requested_mode <= 2'd0;
      state_r.active_mode    <= MODE_BOUNCE;
      state_r.step_index     <= 5'd0;
      state_r.pattern        <= LED_LEFT;
      state_r.count_value    <= 4'd0;
      state_r.count_down     <= 1'b0;
      state_r.wait_left      <= 6'd1;
      state_r.left_bit       <= LED_LEFT;
      state_r.right_bit      <= LED_RIGHT;
      out_valid_r            <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {stepped, state_nxt.pattern};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

endmodule
